>>> rtl/rlc_pkg.sv
package rlc_pkg;

    // table geometry
    localparam int ENTRIES    = 64;
    localparam int LINE_BYTES = 255;
    localparam int MIN_RAW    = 3;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int USED_W = $clog2(ENTRIES + 1);
    localparam int POS_W  = $clog2(LINE_BYTES + 1);
    localparam int LB_AW  = $clog2(LINE_BYTES);
    localparam int TXT_AW = $clog2(ENTRIES * LINE_BYTES + 1);

    localparam logic [7:0] HITS_MAX  = 8'd255;
    localparam logic [7:0] WORDS_MAX = 8'd255;

    // configuration register indexes
    localparam logic CFG_TIP_THRESHOLD = 1'b0;
    localparam logic CFG_WORD_LIMIT    = 1'b1;

    typedef enum logic [2:0] {
        OUT_IGNORED  = 3'd0,
        OUT_STORED   = 3'd1,
        OUT_HIT      = 3'd2,
        OUT_TIP      = 3'd3,
        OUT_FULL     = 3'd4
    } t_outcome;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_META,
        S_TXT_RD,
        S_TXT_CMP,
        S_HIT,
        S_COPY,
        S_COPY_WR,
        S_EMIT
    } t_state;

    // running statistics of the line being received
    typedef struct packed {
        logic [1:0]       raw;
        logic [POS_W-1:0] kept;
        logic [POS_W-1:0] trimmed;
        logic [7:0]       words;
    } t_line_stats;

    // per-entry bookkeeping
    typedef struct packed {
        logic [POS_W-1:0] len;
        logic [7:0]       hits;
    } t_meta;

endpackage

>>> rtl/rlc_in_if.sv
interface rlc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       line_end;

    modport source (output valid, output char_code, output line_end, input ready);
    modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

>>> rtl/rlc_out_if.sv
interface rlc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] outcome;
    logic [7:0] use_count;
    logic [5:0] entry_index;

    modport source (output valid, output outcome, output use_count, output entry_index,
                    input ready);
    modport sink   (input valid, input outcome, input use_count, input entry_index,
                    output ready);
endinterface

>>> rtl/rlc_line_front.sv
module rlc_line_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [7:0]                 i_char,
    input  logic                       i_clear,
    input  logic [rlc_pkg::LB_AW-1:0]  i_raddr,
    output rlc_pkg::t_line_stats       o_stats,
    output logic [7:0]                 o_rdata
);
    import rlc_pkg::*;

    logic [7:0]  r_buf [LINE_BYTES];
    logic [7:0]  r_rdata;
    t_line_stats r_stats;
    t_line_stats n_stats;
    logic        r_inside;
    logic        n_inside;
    logic        blank;
    logic        room;

    assign blank = (i_char == 8'd32) || ((i_char >= 8'd9) && (i_char <= 8'd13));
    assign room  = r_stats.kept < POS_W'(LINE_BYTES);

    // statistics update for one byte
    always_comb begin
        n_stats  = r_stats;
        n_inside = r_inside;
        if (r_stats.raw < 2'(MIN_RAW)) begin
            n_stats.raw = r_stats.raw + 2'd1;
        end
        if (room) begin
            n_stats.kept = r_stats.kept + POS_W'(1);
            if (blank) begin
                n_inside = 1'b0;
            end else begin
                if (!r_inside && (r_stats.words < WORDS_MAX)) begin
                    n_stats.words = r_stats.words + 8'd1;
                end
                n_inside        = 1'b1;
                n_stats.trimmed = r_stats.kept + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_stats  <= '0;
            r_inside <= 1'b0;
        end else if (i_accept) begin
            r_stats  <= n_stats;
            r_inside <= n_inside;
        end
    end

    // line buffer: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_accept && room) begin
            r_buf[r_stats.kept[LB_AW-1:0]] <= i_char;
        end
        r_rdata <= r_buf[i_raddr];
    end

    assign o_stats = r_stats;
    assign o_rdata = r_rdata;

endmodule

>>> rtl/repeated_line_counter.sv
// Repeated line counter.
// i_item carries one byte of a text line per item (char_code, line_end on the
// final byte). o_result carries one item per line: outcome, use_count and
// entry_index. Configuration: i_cfg_we writes i_cfg_data to register
// i_cfg_index (0 tip threshold, 1 word limit). The user must write i_cfg_data
// only while the block is idle; the block itself does not enforce this.
// A byte that is not a line end is taken while the block is idle. At a line
// end intake stops while the table is walked: for each stored entry the
// length is checked, and where the length matches the bytes are compared one
// by one (one port on the line buffer and one on the text memory, each with
// a registered read). A new line is copied into the table byte by byte.
// The result sits in an output register; the next line is taken while it
// waits, but a new result waits until the old one is taken.
// Reset clears the table fill count, the line statistics and the registers
// (threshold 3, word limit 4); the memories need no clearing pass.
module repeated_line_counter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rlc_in_if.sink                i_item,
    rlc_out_if.source             o_result,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [7:0]            i_cfg_data
);
    import rlc_pkg::*;

    t_state              r_state, n_state;
    logic [7:0]          r_thr, r_wlim;
    logic [USED_W-1:0]   r_ent, n_ent;
    logic [USED_W-1:0]   r_used, n_used;
    logic [TXT_AW-1:0]   r_base, n_base;
    logic [POS_W-1:0]    r_j, n_j;
    t_outcome            r_res, n_res;
    logic [7:0]          r_res_cnt, n_res_cnt;
    logic [IDX_W-1:0]    r_res_idx, n_res_idx;
    logic                r_out_valid, n_out_valid;
    t_outcome            r_out, n_out;
    logic [7:0]          r_out_cnt, n_out_cnt;
    logic [IDX_W-1:0]    r_out_idx, n_out_idx;

    t_meta               r_meta [ENTRIES];
    t_meta               r_meta_q;
    logic                meta_we;
    logic [IDX_W-1:0]    meta_waddr;
    t_meta               meta_wdata;

    logic [7:0]          r_text [ENTRIES * LINE_BYTES];
    logic [7:0]          r_txt_q;
    logic                txt_we;
    logic [TXT_AW-1:0]   txt_addr;

    t_line_stats         stats;
    logic [7:0]          lb_q;
    logic                accept;
    logic                clear;
    logic [7:0]          hits_inc;

    assign accept   = i_item.valid && i_item.ready;
    assign txt_addr = r_base + TXT_AW'(r_j);

    rlc_line_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_char  (i_item.char_code),
        .i_clear (clear),
        .i_raddr (r_j[LB_AW-1:0]),
        .o_stats (stats),
        .o_rdata (lb_q)
    );

    assign hits_inc = (r_meta_q.hits < HITS_MAX) ? r_meta_q.hits + 8'd1 : r_meta_q.hits;

    // sequencer: next state, table access and result
    always_comb begin
        n_state     = r_state;
        n_ent       = r_ent;
        n_used      = r_used;
        n_base      = r_base;
        n_j         = r_j;
        n_res       = r_res;
        n_res_cnt   = r_res_cnt;
        n_res_idx   = r_res_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_out_cnt   = r_out_cnt;
        n_out_idx   = r_out_idx;
        meta_we     = 1'b0;
        meta_waddr  = r_ent[IDX_W-1:0];
        meta_wdata  = r_meta_q;
        txt_we      = 1'b0;
        clear       = 1'b0;
        i_item.ready = (r_state == S_IDLE);

        if (o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept && i_item.line_end) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_ent  = '0;
                n_base = '0;
                if ((stats.raw < 2'(MIN_RAW)) || (stats.words <= r_wlim)) begin
                    n_res     = OUT_IGNORED;
                    n_res_cnt = '0;
                    n_res_idx = '0;
                    n_state   = S_EMIT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_j = '0;
                if (r_ent == r_used) begin
                    if (r_used < USED_W'(ENTRIES)) begin
                        n_state = S_COPY;
                    end else begin
                        n_res     = OUT_FULL;
                        n_res_cnt = '0;
                        n_res_idx = '0;
                        n_state   = S_EMIT;
                    end
                end else begin
                    n_state = S_META;
                end
            end
            S_META: begin
                if (r_meta_q.len == stats.trimmed) begin
                    n_state = S_TXT_RD;
                end else begin
                    n_ent   = r_ent + USED_W'(1);
                    n_base  = r_base + TXT_AW'(LINE_BYTES);
                    n_state = S_SCAN;
                end
            end
            S_TXT_RD: begin
                if (r_j == stats.trimmed) begin
                    n_state = S_HIT;
                end else begin
                    n_state = S_TXT_CMP;
                end
            end
            S_TXT_CMP: begin
                if (r_txt_q == lb_q) begin
                    n_j     = r_j + POS_W'(1);
                    n_state = S_TXT_RD;
                end else begin
                    n_ent   = r_ent + USED_W'(1);
                    n_base  = r_base + TXT_AW'(LINE_BYTES);
                    n_state = S_SCAN;
                end
            end
            S_HIT: begin
                meta_we   = 1'b1;
                n_res_cnt = hits_inc;
                n_res_idx = r_ent[IDX_W-1:0];
                if (hits_inc >= r_thr) begin
                    meta_wdata.hits = '0;
                    n_res           = OUT_TIP;
                end else begin
                    meta_wdata.hits = hits_inc;
                    n_res           = OUT_HIT;
                end
                n_state = S_EMIT;
            end
            S_COPY: begin
                if (r_j == stats.trimmed) begin
                    meta_we         = 1'b1;
                    meta_waddr      = r_used[IDX_W-1:0];
                    meta_wdata.len  = stats.trimmed;
                    meta_wdata.hits = 8'd1;
                    n_used          = r_used + USED_W'(1);
                    n_res           = OUT_STORED;
                    n_res_cnt       = 8'd1;
                    n_res_idx       = r_used[IDX_W-1:0];
                    n_state         = S_EMIT;
                end else begin
                    n_state = S_COPY_WR;
                end
            end
            S_COPY_WR: begin
                txt_we  = 1'b1;
                n_j     = r_j + POS_W'(1);
                n_state = S_COPY;
            end
            S_EMIT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_out_cnt   = r_res_cnt;
                    n_out_idx   = r_res_idx;
                    clear       = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= 8'd3;
            r_wlim      <= 8'd4;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TIP_THRESHOLD: r_thr  <= i_cfg_data;
                    CFG_WORD_LIMIT:    r_wlim <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_ent     <= n_ent;
        r_base    <= n_base;
        r_j       <= n_j;
        r_res     <= n_res;
        r_res_cnt <= n_res_cnt;
        r_res_idx <= n_res_idx;
        r_out     <= n_out;
        r_out_cnt <= n_out_cnt;
        r_out_idx <= n_out_idx;
    end

    // entry length and hit count memory
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta[meta_waddr] <= meta_wdata;
        end
        r_meta_q <= r_meta[r_ent[IDX_W-1:0]];
    end

    // entry text memory
    always_ff @(posedge i_clk) begin
        if (txt_we) begin
            r_text[txt_addr] <= lb_q;
        end
        r_txt_q <= r_text[txt_addr];
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.outcome     = r_out;
    assign o_result.use_count   = r_out_cnt;
    assign o_result.entry_index = r_out_idx;

endmodule
